// ===== design/rbsm_pkg.sv =====
// Shared types and constants for the ring buffer span manager.
package rbsm_pkg;

    localparam int MAX_DEPTH = 4096;
    localparam int IDX_W     = $clog2(MAX_DEPTH);
    localparam int LEN_W     = $clog2(MAX_DEPTH + 1);
    localparam int KIND_W    = 2;
    localparam int IN_DATA_W  = ((LEN_W + 7) / 8) * 8;
    localparam int OUT_BITS   = IDX_W + LEN_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [LEN_W-1:0] CAP_MAX   = LEN_W'(MAX_DEPTH);
    localparam logic [LEN_W-1:0] CAP_RESET = LEN_W'(MAX_DEPTH);

    typedef enum logic [KIND_W-1:0] {
        KIND_RESERVE = 2'd0,
        KIND_REWIND  = 2'd1,
        KIND_READ    = 2'd2
    } kind_t;

    typedef struct packed {
        logic [IDX_W-1:0] read_head;
        logic [LEN_W-1:0] held_count;
    } ring_state_t;

    typedef struct packed {
        kind_t            kind;
        logic [LEN_W-1:0] request_length;
    } request_t;

    typedef struct packed {
        logic [IDX_W-1:0] start_index;
        logic [LEN_W-1:0] granted_length;
        logic             error;
    } result_t;

endpackage

// ===== design/rbsm_span_calc.sv =====
// Span arithmetic: grant, start offset and next ring state for one word.
module rbsm_span_calc (
    input  logic [rbsm_pkg::LEN_W-1:0] capacity,
    input  rbsm_pkg::ring_state_t      cur_state,
    input  rbsm_pkg::request_t         req,
    output rbsm_pkg::ring_state_t      next_state,
    output rbsm_pkg::result_t          result
);

    localparam int IW = rbsm_pkg::IDX_W;
    localparam int LW = rbsm_pkg::LEN_W;

    logic [LW-1:0] rh_ext;
    logic [LW-1:0] wh_sum;
    logic          wh_wraps;
    logic [LW-1:0] wh_ext;
    logic [LW-1:0] wr_run;
    logic [LW-1:0] rd_run;
    logic [LW-1:0] wr_grant;
    logic [LW-1:0] rd_grant;
    logic [LW-1:0] rh_sum;
    logic [LW-1:0] rh_new;

    always_comb begin
        rh_ext   = {1'b0, cur_state.read_head};
        wh_sum   = rh_ext + cur_state.held_count;
        wh_wraps = (wh_sum >= capacity);
        wh_ext   = wh_wraps ? (wh_sum - capacity) : wh_sum;

        if (cur_state.held_count >= capacity) begin
            wr_run = '0;
        end else if (wh_ext >= rh_ext) begin
            wr_run = capacity - wh_ext;
        end else begin
            wr_run = rh_ext - wh_ext;
        end
        wr_grant = (req.request_length < wr_run) ? req.request_length : wr_run;

        rd_run   = wh_wraps ? (capacity - rh_ext) : cur_state.held_count;
        rd_grant = (req.request_length < rd_run) ? req.request_length : rd_run;
        rh_sum   = rh_ext + rd_grant;
        rh_new   = (rh_sum >= capacity) ? (rh_sum - capacity) : rh_sum;
    end

    always_comb begin
        next_state = cur_state;
        result     = '0;
        case (req.kind)
            rbsm_pkg::KIND_RESERVE: begin
                result.start_index    = wh_ext[IW-1:0];
                result.granted_length = wr_grant;
                next_state.held_count = cur_state.held_count + wr_grant;
            end
            rbsm_pkg::KIND_REWIND: begin
                if (req.request_length > cur_state.held_count) begin
                    result.error = 1'b1;
                end else begin
                    result.granted_length = req.request_length;
                    next_state.held_count = cur_state.held_count - req.request_length;
                end
            end
            rbsm_pkg::KIND_READ: begin
                result.start_index    = cur_state.read_head;
                result.granted_length = rd_grant;
                next_state.read_head  = rh_new[IW-1:0];
                next_state.held_count = cur_state.held_count - rd_grant;
            end
            default: begin
                next_state = cur_state;
                result     = '0;
            end
        endcase
    end

endmodule

// ===== design/ring_buffer_span_manager.sv =====
// Top level: ring buffer span manager with input and result registers.
// An accepted word waits in the input register; its result is loaded into the result register, which drives m_tvalid.
// Throughput: one word per cycle; the input register advances whenever the
// result register is empty or being taken.
// Reset (aresetn low, synchronous): capacity 4096, read head and held count 0,
// both stages empty. A capacity write empties the ring.
module ring_buffer_span_manager (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rbsm_pkg::LEN_W-1:0]          cfg_data,   // capacity
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rbsm_pkg::IN_DATA_W-1:0]      s_tdata,    // request_length, zero fill
    input  logic [rbsm_pkg::KIND_W-1:0]         s_tuser,    // kind
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rbsm_pkg::OUT_DATA_W-1:0]     m_tdata,    // start_index, granted_length, zero fill
    output logic                                m_tuser     // error
);

    localparam int LW = rbsm_pkg::LEN_W;

    logic [LW-1:0]          capacity_reg;
    logic [LW-1:0]          capacity_next;
    rbsm_pkg::ring_state_t  state_reg;
    rbsm_pkg::ring_state_t  state_next;
    rbsm_pkg::request_t     req_reg;
    logic                   in_valid_reg;
    rbsm_pkg::result_t      result_reg;
    rbsm_pkg::result_t      calc_result;
    logic                   out_valid_reg;
    logic                   out_load;
    logic                   advance;
    logic                   s_accept;
    logic                   cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;

    assign out_load = ~out_valid_reg | m_tready;
    assign advance  = in_valid_reg & out_load;
    assign s_tready = ~in_valid_reg | advance;
    assign s_accept = s_tvalid & s_tready;

    always_comb begin
        if (cfg_data == '0) begin
            capacity_next = LW'(1);
        end else if (cfg_data > rbsm_pkg::CAP_MAX) begin
            capacity_next = rbsm_pkg::CAP_MAX;
        end else begin
            capacity_next = cfg_data;
        end
    end

    rbsm_span_calc u_calc (
        .capacity   (capacity_reg),
        .cur_state  (state_reg),
        .req        (req_reg),
        .next_state (state_next),
        .result     (calc_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg  <= rbsm_pkg::CAP_RESET;
            state_reg     <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_write) begin
                capacity_reg <= capacity_next;
                state_reg    <= '0;
            end else if (advance) begin
                state_reg <= state_next;
            end
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= advance;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_reg.kind           <= rbsm_pkg::kind_t'(s_tuser);
            req_reg.request_length <= s_tdata[LW-1:0];
        end
        if (advance) begin
            result_reg <= calc_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = rbsm_pkg::OUT_DATA_W'({result_reg.granted_length,
                                             result_reg.start_index});
    assign m_tuser  = result_reg.error;

    a_held_le_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.held_count <= capacity_reg)
        else $error("held count exceeds capacity");

    a_head_lt_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, state_reg.read_head} < capacity_reg)
        else $error("read head outside ring");

    a_err_no_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && result_reg.error |-> result_reg.granted_length == '0)
        else $error("error word carries a grant");

    a_cfg_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_write |=> state_reg.held_count == '0 && state_reg.read_head == '0)
        else $error("capacity write did not empty ring");

endmodule
